// ----- sv/shrinking_box_edge_bias_flagger_core_defines.svh -----
// ----------------------------------------------------------------------------
// Shrinking box edge bias flagger defines
// Assertion macros for the core module of the block.
// ----------------------------------------------------------------------------
`ifndef SHRINKING_BOX_EDGE_BIAS_FLAGGER_CORE_DEFINES_SVH
`define SHRINKING_BOX_EDGE_BIAS_FLAGGER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SBF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// Shrinking box edge bias flagger package
// Shared constants, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

  localparam int PHASE_COUNT_DEF = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int CMD_W       = 2;
  localparam int PHASE_W     = 4;
  localparam int SIDE_COUNT  = 6;
  localparam int SIDE_IDX_W  = 3;
  localparam int FLAT_SIDES  = 4;
  localparam int REG_COUNT   = 8;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = $clog2(REG_COUNT) + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_SHRINK  = 2'd1,
    CMD_TEST    = 2'd2
  } cmd_t;

  typedef enum logic [$clog2(REG_COUNT)-1:0] {
    REG_INIT_X_LOW  = 3'd0,
    REG_INIT_X_HIGH = 3'd1,
    REG_INIT_Y_LOW  = 3'd2,
    REG_INIT_Y_HIGH = 3'd3,
    REG_INIT_Z_LOW  = 3'd4,
    REG_INIT_Z_HIGH = 3'd5,
    REG_BY_PHASE    = 3'd6,
    REG_FLAT        = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- sv/sbf_item_if.sv -----
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel that carries one command with its centroid.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbf_item_if #(
  parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF
);
  import sbf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [PHASE_W-1:0]     phase;
  logic                   is_surface;
  logic [COORD_WIDTH-1:0] pos_x;
  logic [COORD_WIDTH-1:0] pos_y;
  logic [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, cmd, phase, is_surface, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, cmd, phase, is_surface, pos_x, pos_y, pos_z,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/sbf_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbf_result_if;
  import sbf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  biased;
  logic                  side_moved;
  logic [SIDE_IDX_W-1:0] side_index;

  modport source (output valid, biased, side_moved, side_index, input ready);
  modport sink   (input valid, biased, side_moved, side_index, output ready);
endinterface

`default_nettype wire

// ----- sv/sbf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ram #(
  parameter int WIDTH = sbf_pkg::COORD_WIDTH_DEF,
  parameter int DEPTH = sbf_pkg::PHASE_COUNT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/shrinking_box_edge_bias_flagger_core.sv -----
// ----------------------------------------------------------------------------
// Shrinking box edge bias flagger
// Per-phase boxes in one RAM, read at accept, updated in the compute stage.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  item     in         valid/ready            cmd, phase, is_surface, pos_x/y/z
//  result   out        valid/ready            biased, side_moved, side_index
//  APB      in         psel/penable, pready=1 init box, by_phase_mode, flat_mode
//
// One item per cycle while no result stalls; an accepted item passes the compute stage, then the output register.
// The box RAM is read at accept and written when the compute stage hands its
// result to the output register; the last write is forwarded to a later read.
// A stalled result holds the compute stage, and the item channel then waits.
// Reset clears control and registers only; box entries hold nothing until a
// restart writes them, so there is no clearing pass.
`default_nettype none

`include "shrinking_box_edge_bias_flagger_core_defines.svh"

module shrinking_box_edge_bias_flagger_core #(
  parameter int PHASE_COUNT = sbf_pkg::PHASE_COUNT_DEF,
  parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sbf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sbf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  sbf_item_if.sink                          item,
  sbf_result_if.source                      result
);
  import sbf_pkg::*;

  localparam int IDX_W   = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam int CW      = COORD_WIDTH;
  localparam int BOX_W   = SIDE_COUNT * CW;
  localparam int PEXT_W  = 9;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [APB_DATA_W-1:0] init_raw [SIDE_COUNT];
  logic                  by_phase;
  logic                  flat;
  logic                  cfg_we;
  reg_idx_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_COUNT; i++) begin
        init_raw[i] <= '0;
      end
      by_phase <= 1'b0;
      flat     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BY_PHASE: by_phase <= pwdata[0];
        REG_FLAT:     flat     <= pwdata[0];
        default:      init_raw[cfg_idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BY_PHASE: prdata = APB_DATA_W'(by_phase);
      REG_FLAT:     prdata = APB_DATA_W'(flat);
      default:      prdata = init_raw[cfg_idx];
    endcase
  end

  // --------------------------------------------------------------------------
  // Accept stage: entry select and RAM read
  // --------------------------------------------------------------------------
  logic              accept;
  logic              s1_advance;
  logic [PEXT_W-1:0] phase_ext;
  logic              in_ignore;
  logic [IDX_W-1:0]  in_entry;

  assign phase_ext = PEXT_W'(item.phase);
  assign in_ignore = by_phase && (phase_ext >= PEXT_W'(PHASE_COUNT));
  assign in_entry  = by_phase ? phase_ext[IDX_W-1:0] : '0;
  assign accept    = item.valid && item.ready;

  logic                        s1_valid;
  logic [CMD_W-1:0]            s1_cmd;
  logic [IDX_W-1:0]            s1_entry;
  logic                        s1_ignore;
  logic                        s1_surf;
  logic [2:0][CW-1:0]          s1_pos;

  logic                        out_valid;
  logic                        out_biased;
  logic                        out_moved;
  logic [SIDE_IDX_W-1:0]       out_side;

  assign s1_advance = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_cmd    <= item.cmd;
      s1_entry  <= in_entry;
      s1_ignore <= in_ignore;
      s1_surf   <= item.is_surface;
      s1_pos    <= {item.pos_z, item.pos_y, item.pos_x};
    end
  end

  // --------------------------------------------------------------------------
  // Box RAM with forwarding of the most recent write
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic [BOX_W-1:0] ram_wdata;
  logic [BOX_W-1:0] ram_rdata;
  logic             lw_valid;
  logic [IDX_W-1:0] lw_entry;
  logic [BOX_W-1:0] lw_data;

  sbf_ram #(
    .WIDTH (BOX_W),
    .DEPTH (PHASE_COUNT)
  ) u_box_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_entry),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_entry),
    .rdata (ram_rdata)
  );

  // The register always holds the latest write, so it is safe to prefer it
  // on a match even when the RAM has already absorbed that write.
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (ram_we) begin
      lw_valid <= 1'b1;
    end
    if (ram_we) begin
      lw_entry <= s1_entry;
      lw_data  <= ram_wdata;
    end
  end

  logic [SIDE_COUNT-1:0][CW-1:0] box;
  assign box = (lw_valid && (lw_entry == s1_entry)) ? lw_data : ram_rdata;

  // --------------------------------------------------------------------------
  // Compute stage: side distances, inside test, nearest side
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   side_val  [SIDE_COUNT];
  logic signed [CW-1:0]   cen_val   [SIDE_COUNT];
  logic signed [CW:0]     side_dist [SIDE_COUNT];
  logic [SIDE_COUNT-1:0]  active;
  logic [SIDE_COUNT-1:0]  dist_pos;
  logic [SIDE_COUNT-1:0]  cand;
  logic                   in_box;
  logic                   hit;
  logic                   moved;
  logic                   restart;
  logic [SIDE_IDX_W-1:0]  best;

  always_comb begin
    for (int s = 0; s < SIDE_COUNT; s++) begin
      side_val[s] = $signed(box[s]);
      cen_val[s]  = $signed(s1_pos[s / 2]);
      if (s % 2 == 1) begin
        side_dist[s] = (CW + 1)'(side_val[s]) - (CW + 1)'(cen_val[s]);
      end else begin
        side_dist[s] = (CW + 1)'(cen_val[s]) - (CW + 1)'(side_val[s]);
      end
      active[s]   = (s < FLAT_SIDES) || !flat;
      dist_pos[s] = side_dist[s] > 0;
    end
  end

  assign in_box = &(dist_pos | ~active);
  assign hit    = |(~dist_pos & active);

  // A side wins if it beats every lower active side strictly and ties or
  // beats every higher one, which gives the lowest index on a tie.
  always_comb begin
    for (int s = 0; s < SIDE_COUNT; s++) begin
      cand[s] = active[s];
      for (int j = 0; j < SIDE_COUNT; j++) begin
        if (active[j] && (j < s)) begin
          cand[s] = cand[s] && (side_dist[s] < side_dist[j]);
        end else if (active[j] && (j > s)) begin
          cand[s] = cand[s] && (side_dist[s] <= side_dist[j]);
        end
      end
    end
    best = '0;
    for (int s = SIDE_COUNT - 1; s >= 0; s--) begin
      if (cand[s]) begin
        best = SIDE_IDX_W'(s);
      end
    end
  end

  assign restart = (s1_cmd == CMD_RESTART);
  assign moved   = (s1_cmd == CMD_SHRINK) && s1_surf && in_box && !s1_ignore;
  assign ram_we  = s1_advance && !s1_ignore && (restart || moved);

  always_comb begin
    for (int s = 0; s < SIDE_COUNT; s++) begin
      if (restart) begin
        ram_wdata[s*CW +: CW] = CW'(init_raw[s]);
      end else if (best == SIDE_IDX_W'(s)) begin
        ram_wdata[s*CW +: CW] = cen_val[s];
      end else begin
        ram_wdata[s*CW +: CW] = box[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      out_biased <= (s1_cmd == CMD_TEST) && hit && !s1_ignore;
      out_moved  <= moved;
      out_side   <= moved ? best : '0;
    end
  end

  assign result.valid      = out_valid;
  assign result.biased     = out_biased;
  assign result.side_moved = out_moved;
  assign result.side_index = out_side;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SBF_ASSERT_SAME(a_flat_side, clk, rst, result.valid && result.side_moved && flat,
                   result.side_index < SIDE_IDX_W'(FLAT_SIDES),
                   "flat mode moved a z side")
  `SBF_ASSERT_SAME(a_one_flag, clk, rst, result.valid,
                   !(result.biased && result.side_moved),
                   "result flags both bias and a moved side")
  `SBF_ASSERT_NEXT(a_advance_out, clk, rst, s1_advance, out_valid,
                   "compute stage advanced without a result")
  `SBF_ASSERT_SAME(a_write_valid, clk, rst, ram_we, s1_valid && !s1_ignore,
                   "box write without a valid item")

endmodule

`default_nettype wire

// ----- test/shrinking_box_edge_bias_flagger_core_test.sv -----
// ----------------------------------------------------------------------------
// Shrinking box edge bias flagger testbench
// Drives command transactions with random gaps and result stalls, predicts
// every result from a shadow copy of the per-phase boxes and compares the
// results field by field. The initial box, phase mode and flat mode are
// reprogrammed over APB between runs, once the block has gone idle.
// ----------------------------------------------------------------------------
module shrinking_box_edge_bias_flagger_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbf_pkg::*;

  localparam int PHASES     = PHASE_COUNT_DEF;
  localparam int COORD_W    = COORD_WIDTH_DEF;
  localparam int QUIET_MAX  = 1000;
  localparam int RAND_RUNS  = 8;
  localparam int RUN_ITEMS  = 216;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [PHASE_W-1:0]      phase;
    logic                    surface;
    logic [2:0][COORD_W-1:0] pos;
  } box_item_t;

  typedef struct packed {
    logic                  biased;
    logic                  side_moved;
    logic [SIDE_IDX_W-1:0] side_index;
  } flag_result_t;

  typedef struct packed {
    logic [PHASES-1:0]                             written;
    logic [SIDE_COUNT-1:0][PHASES-1:0][COORD_W-1:0] side;
  } box_store_t;

  typedef struct packed {
    logic [SIDE_COUNT-1:0][COORD_W-1:0] init;
    logic                               by_phase;
    logic                               flat;
  } box_cfg_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sbf_item_if #(.COORD_WIDTH(COORD_W)) item_ch ();
  sbf_result_if                        result_ch ();

  shrinking_box_edge_bias_flagger_core uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  box_item_t    cmd_q[$];
  flag_result_t flags_due[$];
  box_store_t   gen_store;
  box_store_t   chk_store;
  box_cfg_t     cfg_now;
  box_item_t    on_wire;
  bit           item_taken;
  int           send_gap;
  int           send_rate;
  int           stall_left;
  int           stall_rate;
  int           quiet_cycles;
  int           fail_count;
  int           items_done;
  int           moves_seen;
  int           biased_seen;
  int           settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [63:0] wide(input logic signed [COORD_W-1:0] v);
    return v;
  endfunction

  // Applies one command to a box store and returns the result it produces.
  function automatic flag_result_t box_step(inout box_store_t st, input box_cfg_t cf,
                                            input box_item_t it);
    flag_result_t       r;
    int                 e;
    int                 n_sides;
    int                 s;
    int                 best;
    logic signed [63:0] b;
    logic signed [63:0] c;
    logic signed [63:0] d;
    logic signed [63:0] best_d;
    logic               ok;
    r = '0;
    e = cf.by_phase ? int'(it.phase) : 0;
    n_sides = cf.flat ? FLAT_SIDES : SIDE_COUNT;
    ok = 1'b1;
    best = 0;
    best_d = 0;
    case (it.cmd)
      CMD_RESTART: begin
        for (s = 0; s < SIDE_COUNT; s++) st.side[s][e] = cf.init[s];
        st.written[e] = 1'b1;
      end
      CMD_SHRINK: begin
        if (it.surface) begin
          for (s = 0; s < n_sides; s++) begin
            b = wide(st.side[s][e]);
            c = wide(it.pos[s / 2]);
            d = (s % 2 == 1) ? b - c : c - b;
            if (ok && d <= 0) begin
              ok = 1'b0;
            end else if (ok && (s == 0 || d < best_d)) begin
              best_d = d;
              best = s;
            end
          end
          if (ok) begin
            st.side[best][e] = it.pos[best / 2];
            r.side_moved = 1'b1;
            r.side_index = SIDE_IDX_W'(best);
          end
        end
      end
      CMD_TEST: begin
        for (s = 0; s < n_sides; s++) begin
          b = wide(st.side[s][e]);
          c = wide(it.pos[s / 2]);
          if ((s % 2 == 1) ? (c >= b) : (c <= b)) r.biased = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic box_item_t make_item(input logic [CMD_W-1:0] cmd, input int phase,
                                          input bit surface, input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] z);
    box_item_t it;
    it.cmd = cmd;
    it.phase = PHASE_W'(phase);
    it.surface = surface;
    it.pos[0] = x;
    it.pos[1] = y;
    it.pos[2] = z;
    return it;
  endfunction

  // Picks a coordinate for one axis: mostly strictly inside the box, otherwise
  // on a side, just beyond one, just inside the upper one, at the middle or anywhere at all.
  function automatic logic [COORD_W-1:0] pick_coord(input logic signed [63:0] lo,
                                                    input logic signed [63:0] hi,
                                                    input bit loose);
    logic signed [63:0] v;
    logic [63:0]        span;
    v = lo + 1;
    if (!loose && hi - lo >= 2) begin
      span = hi - lo - 1;
      v = lo + 1 + ({$urandom, $urandom} % span);
    end else begin
      case ($urandom_range(0, 6))
        0: v = {$urandom, $urandom};
        1: v = lo;
        2: v = hi;
        3: v = lo - $urandom_range(1, 40);
        4: v = hi + $urandom_range(1, 40);
        5: v = (lo + hi) >>> 1;
        default: v = hi - 1;
      endcase
    end
    return v[COORD_W-1:0];
  endfunction

  task automatic queue_item(input box_item_t it);
    flag_result_t unused_r;
    unused_r = box_step(gen_store, cfg_now, it);
    cmd_q.push_back(it);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BY_PHASE: cfg_now.by_phase = value[0];
      REG_FLAT:     cfg_now.flat = value[0];
      default:      cfg_now.init[idx] = value;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every queued command has gone in and every result has come
  // out, then lets the two pipeline stages settle.
  task automatic drain();
    while (cmd_q.size() != 0 || item_ch.valid || flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_box(input logic [SIDE_COUNT-1:0][COORD_W-1:0] sides,
                             input bit by_phase, input bit flat);
    int s;
    for (s = 0; s < SIDE_COUNT; s++) write_reg(reg_idx_t'(s), sides[s]);
    write_reg(REG_BY_PHASE, {31'd0, by_phase});
    write_reg(REG_FLAT, {31'd0, flat});
    settings_used++;
  endtask

  task automatic random_settings(input int run);
    logic [SIDE_COUNT-1:0][COORD_W-1:0] sides;
    logic signed [COORD_W-1:0]          lo;
    int                                 a;
    bit                                 by_phase;
    bit                                 flat;
    for (a = 0; a < 3; a++) begin
      case ($urandom_range(0, 5))
        0: begin
          sides[2 * a]     = 32'h8000_0000;
          sides[2 * a + 1] = 32'h7fff_ffff;
        end
        1: begin
          lo = $urandom;
          sides[2 * a]     = lo;
          sides[2 * a + 1] = lo - $urandom_range(0, 3);
        end
        2: begin
          lo = $urandom;
          sides[2 * a]     = lo;
          sides[2 * a + 1] = lo + $urandom_range(2, 1 << 24);
        end
        default: begin
          lo = $urandom_range(0, 1 << 17) - (1 << 16);
          sides[2 * a]     = lo;
          sides[2 * a + 1] = lo + $urandom_range(2, 300);
        end
      endcase
    end
    by_phase = (run < 4) ? run[0] : 1'($urandom_range(0, 1));
    flat     = (run < 4) ? run[1] : 1'($urandom_range(0, 1));
    program_box(sides, by_phase, flat);
  endtask

  task automatic random_items(input int count);
    box_item_t          it;
    int                 n;
    int                 k;
    int                 a;
    int                 e;
    bit                 loose;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    for (n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 8)       it.cmd = CMD_RESTART;
      else if (k < 10) it.cmd = CMD_UNUSED;
      else if (k < 60) it.cmd = CMD_SHRINK;
      else             it.cmd = CMD_TEST;
      it.phase = ($urandom_range(0, 3) == 0) ? PHASE_W'($urandom_range(0, PHASES - 1))
                                             : PHASE_W'($urandom_range(0, 3));
      it.surface = ($urandom_range(0, 9) != 0);
      e = cfg_now.by_phase ? int'(it.phase) : 0;
      // A box that no restart has loaded holds nothing to compare against.
      if (!gen_store.written[e]) it.cmd = CMD_RESTART;
      loose = ($urandom_range(0, 3) == 0);
      for (a = 0; a < 3; a++) begin
        lo = wide(gen_store.side[2 * a][e]);
        hi = wide(gen_store.side[2 * a + 1][e]);
        if (a == 2 && cfg_now.flat) it.pos[a] = $urandom;
        else                        it.pos[a] = pick_coord(lo, hi, loose);
      end
      queue_item(it);
    end
  endtask

  // Sender: holds each transaction until it is taken, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (item_taken || !item_ch.valid) begin
      item_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        item_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0 && send_rate != 0 && $urandom_range(0, 15) < send_rate) begin
        send_gap = $urandom_range(1, 19) - 1;
        item_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        on_wire = cmd_q.pop_front();
        item_ch.cmd        <= on_wire.cmd;
        item_ch.phase      <= on_wire.phase;
        item_ch.is_surface <= on_wire.surface;
        item_ch.pos_x      <= on_wire.pos[0];
        item_ch.pos_y      <= on_wire.pos[1];
        item_ch.pos_z      <= on_wire.pos[2];
        item_ch.valid      <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts on the result channel.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
      stall_left = $urandom_range(1, 19) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : item_accept
    flag_result_t r;
    if (!rst && item_ch.valid && item_ch.ready) begin
      r = box_step(chk_store, cfg_now, on_wire);
      flags_due.push_back(r);
      item_taken = 1'b1;
      items_done++;
      if (r.side_moved) moves_seen++;
      if (r.biased) biased_seen++;
    end
  end

  always @(posedge clk) begin : result_check
    flag_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (flags_due.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: biased=%0b side_moved=%0b side_index=%0d",
                 $realtime, result_ch.biased, result_ch.side_moved, result_ch.side_index);
      end else begin
        want = flags_due.pop_front();
        if (result_ch.biased !== want.biased) begin
          fail_count++;
          $display("%0t: biased expected %0b, got %0b", $realtime, want.biased,
                   result_ch.biased);
        end
        if (result_ch.side_moved !== want.side_moved) begin
          fail_count++;
          $display("%0t: side_moved expected %0b, got %0b", $realtime, want.side_moved,
                   result_ch.side_moved);
        end
        if (result_ch.side_index !== want.side_index) begin
          fail_count++;
          $display("%0t: side_index expected %0d, got %0d", $realtime, want.side_index,
                   result_ch.side_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $realtime,
                 QUIET_MAX, flags_due.size());
        $display("shrinking_box_edge_bias_flagger_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int run;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = '0;
    item_ch.phase = '0;
    item_ch.is_surface = 1'b0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    result_ch.ready = 1'b0;
    gen_store = '0;
    chk_store = '0;
    cfg_now = '0;
    item_taken = 1'b0;
    send_gap = 0;
    stall_left = 0;
    send_rate = 3;
    stall_rate = 3;
    quiet_cycles = 0;
    fail_count = 0;
    items_done = 0;
    moves_seen = 0;
    biased_seen = 0;
    settings_used = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Cube of half size ten, one shared box, all three axes active.
    program_box({32'd10, -32'sd10, 32'd10, -32'sd10, 32'd10, -32'sd10}, 1'b0, 1'b0);
    queue_item(make_item(CMD_RESTART, 3, 1'b0, 0, 0, 0));
    queue_item(make_item(CMD_TEST, 0, 1'b0, 0, 0, 0));
    queue_item(make_item(CMD_TEST, 0, 1'b1, -10, 0, 0));
    queue_item(make_item(CMD_TEST, 0, 1'b0, 0, 0, 10));
    queue_item(make_item(CMD_SHRINK, 0, 1'b0, 0, 0, 0));
    // Centered point: all six distances tie and the lowest side moves.
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 0, 0, 0));
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 5, 0, 0));
    // Upper x and lower z are equally near; upper x wins.
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 9, 0, -9));
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 20, 0, 0));
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 5, 1, 1));
    queue_item(make_item(CMD_UNUSED, 0, 1'b1, 1, 1, 1));
    queue_item(make_item(CMD_TEST, 15, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    queue_item(make_item(CMD_TEST, 15, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    queue_item(make_item(CMD_SHRINK, 15, 1'b1, 32'h8000_0000, 32'h8000_0000, 0));
    drain();

    // Widest possible x and y with a collapsed z range, per-phase boxes, flat.
    program_box({32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
                1'b1, 1'b1);
    queue_item(make_item(CMD_RESTART, 15, 1'b0, 0, 0, 0));
    queue_item(make_item(CMD_RESTART, 0, 1'b1, 0, 0, 0));
    queue_item(make_item(CMD_TEST, 15, 1'b0, 0, 0, 5));
    queue_item(make_item(CMD_SHRINK, 15, 1'b1, 0, 0, 7));
    queue_item(make_item(CMD_TEST, 0, 1'b0, 32'h7fff_ffff, 0, 0));
    queue_item(make_item(CMD_TEST, 15, 1'b0, 1, 0, 0));
    queue_item(make_item(CMD_SHRINK, 0, 1'b1, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0000));
    drain();

    for (run = 0; run < RAND_RUNS; run++) begin
      random_settings(run);
      if (run == RAND_RUNS - 1) begin
        send_rate = 0;
        stall_rate = 0;
      end else begin
        send_rate = $urandom_range(0, 4);
        stall_rate = $urandom_range(0, 4);
      end
      random_items(RUN_ITEMS);
      drain();
    end
    repeat (8) @(posedge clk);

    $display("Ran %0d commands under %0d register settings.", items_done, settings_used);
    $display("The box shrank %0d times and %0d centroids were flagged as biased.",
             moves_seen, biased_seen);
    if (fail_count == 0) begin
      $display("shrinking_box_edge_bias_flagger_core_test OK");
    end else begin
      $display("shrinking_box_edge_bias_flagger_core_test NOT OK");
    end
    $finish;
  end

endmodule
